@@ sv/assert_macros.svh @@
// assertion macros used by the datapath rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the default clock and reset names
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_ON(label, clk_i, rst_ni, prop, msg)

`endif

@@ sv/ksu_pkg.sv @@
// package: types, constants and codes of the ks uniform statistic block
package ksu_pkg;

  localparam int THRESHOLDS_DEF  = 100;
  localparam int MAX_SAMPLES_DEF = 1000;
  localparam int SAMPLES_W       = 10;
  localparam int FMT_W           = 2;

  localparam logic [FMT_W-1:0] FMT_BYTE = 2'd0;
  localparam logic [FMT_W-1:0] FMT_WORD = 2'd1;
  localparam logic [FMT_W-1:0] FMT_HIGH = 2'd2;

  typedef struct packed {
    logic [63:0] sample_raw;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]    k_plus;
    logic signed [31:0]    k_minus;
    logic [SAMPLES_W-1:0]  samples_used;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic rd_bin;
    logic wr_bin;
    logic walk_init;
    logic walk_rd;
    logic walk_acc;
    logic walk_cmp;
    logic sqrt_step;
    logic mul_p;
    logic mul_m;
    logic div_step;
    logic load_out;
  } ksu_cmd_t;

  typedef struct packed {
    logic last;
    logic walk_last;
    logic sqrt_last;
    logic div_last;
    logic out_free;
  } ksu_sts_t;

endpackage

@@ sv/ksu_ctrl.sv @@
// controller state machine sequencing sample update, bin walk, root and divisions
module ksu_ctrl import ksu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ksu_sts_t sts_i,
  output ksu_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_WR   = 4'd2;
  localparam logic [3:0] S_WRD  = 4'd3;
  localparam logic [3:0] S_WACC = 4'd4;
  localparam logic [3:0] S_WCMP = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_MULP = 4'd7;
  localparam logic [3:0] S_DIVP = 4'd8;
  localparam logic [3:0] S_MULM = 4'd9;
  localparam logic [3:0] S_DIVM = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_bin = 1'b1;
        state_d      = S_WR;
      end
      S_WR: begin
        cmd_o.wr_bin = 1'b1;
        if (sts_i.last) begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_WRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WRD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_WACC;
      end
      S_WACC: begin
        cmd_o.walk_acc = 1'b1;
        state_d        = S_WCMP;
      end
      S_WCMP: begin
        cmd_o.walk_cmp = 1'b1;
        state_d        = sts_i.walk_last ? S_SQRT : S_WRD;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = S_MULP;
      end
      S_MULP: begin
        cmd_o.mul_p = 1'b1;
        state_d     = S_DIVP;
      end
      S_DIVP: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_MULM;
      end
      S_MULM: begin
        cmd_o.mul_m = 1'b1;
        state_d     = S_DIVM;
      end
      S_DIVM: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ sv/ksu_dp.sv @@
// datapath: histogram memory, bin walk, integer root, shared divider, result register
`include "assert_macros.svh"
module ksu_dp import ksu_pkg::*; #(
  parameter int THRESHOLDS  = THRESHOLDS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_item_t         in_item_i,
  input  logic             cfg_valid_i,
  input  logic [FMT_W-1:0] cfg_data_i,
  input  ksu_cmd_t         cmd_i,
  output ksu_sts_t         sts_o,
  output logic             out_valid_o,
  output out_item_t        out_item_o,
  input  logic             out_stall_i
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int TW    = $clog2(THRESHOLDS + 1);
  localparam int IW    = $clog2(THRESHOLDS);
  localparam int DW    = CNT_W + TW;
  localparam int VW    = CNT_W + 32 + (CNT_W % 2);
  localparam int SW    = VW / 2;
  localparam int PW    = DW + SW;
  localparam int SCW   = $clog2(SW);
  localparam int DCW   = $clog2(PW);

  logic [FMT_W-1:0] fmt_q;
  logic [31:0]      u_q;
  logic             uvld_q, last_q;
  logic [CNT_W-1:0] cnt_q;
  logic             taken_q, inrange_q;
  logic [IW-1:0]    bin_q;
  logic [32+TW-1:0] bin_prod;
  logic [TW-1:0]    bin_c;
  logic             inrange_c;
  logic [IW-1:0]    rd_addr;
  logic [CNT_W-1:0] mem_q [THRESHOLDS];
  logic [CNT_W-1:0] rd_q, rd_val;
  logic             rd_vld_q;
  logic [THRESHOLDS-1:0] vld_q;
  logic             wr_en;
  logic [IW-1:0]    idx_q;
  logic [CNT_W-1:0] cum_q;
  logic [DW-1:0]    b_q, a_c, dp_q, dm_q, denom_q;
  logic             have_p_q, have_m_q;
  logic [VW-1:0]    v_q;
  logic [SW+1:0]    rem_q, rem_t, trial;
  logic [SW-1:0]    root_q;
  logic [SCW-1:0]   sq_cnt_q;
  logic [PW-1:0]    div_num_q;
  logic [DW-1:0]    div_rem_q;
  logic [DW:0]      drem_t;
  logic             dge;
  logic [DCW-1:0]   div_cnt_q;
  logic [31:0]      kp_q, neg_s, quot32;
  logic             out_valid_q;
  out_item_t        out_item_q;

  assign bin_prod  = (32+TW)'(u_q) * (32+TW)'(THRESHOLDS) + (32+TW)'(33'h0_FFFF_FFFF);
  assign bin_c     = bin_prod[32+TW-1:32];
  assign inrange_c = (bin_c < TW'(THRESHOLDS));
  assign rd_addr   = cmd_i.walk_rd ? idx_q : bin_c[IW-1:0];
  assign rd_val    = rd_vld_q ? rd_q : '0;
  assign wr_en     = cmd_i.wr_bin && taken_q && inrange_q;
  assign a_c       = DW'(cum_q) * DW'(THRESHOLDS);
  assign rem_t     = {rem_q[SW-1:0], v_q[VW-1:VW-2]};
  assign trial     = {root_q, 2'b01};
  assign drem_t    = {div_rem_q, div_num_q[PW-1]};
  assign dge       = (drem_t >= {1'b0, denom_q});
  assign neg_s     = 32'(0) - 32'(root_q);
  assign quot32    = 32'(div_num_q[SW-1:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[bin_q] <= rd_val + CNT_W'(1);
    rd_q     <= mem_q[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_BYTE;
      cnt_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) fmt_q <= cfg_data_i;
      if (cmd_i.rd_bin && uvld_q && (cnt_q < CNT_W'(MAX_SAMPLES))) cnt_q <= cnt_q + CNT_W'(1);
      if (wr_en) vld_q[bin_q] <= 1'b1;
      if (cmd_i.walk_acc) vld_q[idx_q] <= 1'b0;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      last_q <= in_item_i.last_sample;
      case (fmt_q)
        FMT_BYTE: begin
          u_q    <= {in_item_i.sample_raw[7:0], 24'h0};
          uvld_q <= 1'b1;
        end
        FMT_WORD: begin
          u_q    <= in_item_i.sample_raw[31:0];
          uvld_q <= 1'b1;
        end
        FMT_HIGH: begin
          u_q    <= in_item_i.sample_raw[63:32];
          uvld_q <= 1'b1;
        end
        default: begin
          u_q    <= '0;
          uvld_q <= 1'b0;
        end
      endcase
    end
    if (cmd_i.rd_bin) begin
      taken_q   <= uvld_q && (cnt_q < CNT_W'(MAX_SAMPLES));
      bin_q     <= bin_c[IW-1:0];
      inrange_q <= inrange_c;
    end
    if (cmd_i.walk_init) begin
      idx_q    <= '0;
      cum_q    <= '0;
      b_q      <= '0;
      dp_q     <= '0;
      dm_q     <= '0;
      have_p_q <= 1'b0;
      have_m_q <= 1'b0;
      denom_q  <= DW'(cnt_q) * DW'(THRESHOLDS);
      v_q      <= VW'(cnt_q) << 32;
      rem_q    <= '0;
      root_q   <= '0;
      sq_cnt_q <= '0;
    end
    if (cmd_i.walk_acc) cum_q <= cum_q + rd_val;
    if (cmd_i.walk_cmp) begin
      if (a_c > b_q) begin
        if (!have_p_q || ((a_c - b_q) > dp_q)) dp_q <= a_c - b_q;
        have_p_q <= 1'b1;
      end else if (b_q > a_c) begin
        if (!have_m_q || ((b_q - a_c) > dm_q)) dm_q <= b_q - a_c;
        have_m_q <= 1'b1;
      end
      b_q   <= b_q + DW'(cnt_q);
      idx_q <= idx_q + IW'(1);
    end
    if (cmd_i.sqrt_step) begin
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[SW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[SW-2:0], 1'b0};
      end
      v_q      <= v_q << 2;
      sq_cnt_q <= sq_cnt_q + SCW'(1);
    end
    if (cmd_i.mul_p || cmd_i.mul_m) begin
      div_num_q <= PW'(cmd_i.mul_p ? dp_q : dm_q) * PW'(root_q);
      div_rem_q <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.mul_m) kp_q <= have_p_q ? quot32 : neg_s;
    if (cmd_i.div_step) begin
      div_rem_q <= dge ? DW'(drem_t - {1'b0, denom_q}) : drem_t[DW-1:0];
      div_num_q <= {div_num_q[PW-2:0], dge};
      div_cnt_q <= div_cnt_q + DCW'(1);
    end
    if (cmd_i.load_out) begin
      out_item_q.k_plus       <= kp_q;
      out_item_q.k_minus      <= have_m_q ? quot32 : neg_s;
      out_item_q.samples_used <= SAMPLES_W'(cnt_q);
    end
  end

  assign sts_o.last      = last_q;
  assign sts_o.walk_last = (idx_q == IW'(THRESHOLDS - 1));
  assign sts_o.sqrt_last = (sq_cnt_q == SCW'(SW - 1));
  assign sts_o.div_last  = (div_cnt_q == DCW'(PW - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;

  `ASSERT_DEF(a_cnt_cap, cnt_q <= CNT_W'(MAX_SAMPLES), "sample count above cap")
  `ASSERT_DEF(a_walk_clears, cmd_i.walk_cmp && sts_o.walk_last |=> vld_q == '0, "histogram not cleared")
  `ASSERT_DEF(a_quot_bound, cmd_i.div_step && sts_o.div_last && denom_q != '0 |=> div_num_q <= PW'(root_q), "quotient above root")

endmodule

@@ sv/kolmogorov_smirnov_uniform_statistic.sv @@
// top level: ks statistic of a sample stream against the uniform distribution
// an ordinary item is accepted, then its histogram bin is read, then written back
// an item marked last then also runs a read, accumulate and compare step per bin,
// SW root steps, and two PW-step divisions on one divider
// a finished result waits in the output register while the next item is taken
// reset clears the histogram valid bits, sample count and format register at once
module kolmogorov_smirnov_uniform_statistic import ksu_pkg::*; #(
  parameter int THRESHOLDS  = THRESHOLDS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [FMT_W-1:0] cfg_data_i
);

  ksu_cmd_t cmd;
  ksu_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ksu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ksu_dp #(
    .THRESHOLDS  (THRESHOLDS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule
